### sv/pfv_pkg.sv
// ----------------------------------------------------------------------------
// pfv_pkg - shared definitions for the polygon vertex generator
// Field widths, arithmetic constants, state types and the control structs
// that pass between the sequencers and the serial arithmetic units.
// ----------------------------------------------------------------------------
package pfv_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 22;
  localparam int COUNT_W  = 5;
  localparam int ANGLE_W  = 16;
  localparam int INDEX_W  = 4;
  localparam int TRIG_W   = 16;

  localparam int MUL_W       = 32;
  localparam int MUL_DIGIT_W = 4;
  localparam int PROD_W      = 2 * MUL_W;

  localparam int DIV_W     = 32;
  localparam int DIVISOR_W = 8;

  localparam int HORNER_STEPS = 6;

  localparam logic [MUL_W-1:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0]      Q30_ONE = 31'h4000_0000;

  function automatic logic [DIVISOR_W-1:0] horner_div(input logic [2:0] k);
    logic [DIVISOR_W-1:0] d;
    case (k)
      3'd0:    d = 8'd156;
      3'd1:    d = 8'd110;
      3'd2:    d = 8'd72;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd20;
      3'd5:    d = 8'd6;
      default: d = 8'd6;
    endcase
    return d;
  endfunction

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quot;
    logic [DIVISOR_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    SIN_IDLE,
    SIN_X,
    SIN_SQ,
    SIN_HMUL,
    SIN_HDIV,
    SIN_FIN
  } sine_state_t;

  typedef enum logic [2:0] {
    PF_IDLE,
    PF_STEP,
    PF_LAUNCH,
    PF_COS,
    PF_COS_SCALE,
    PF_SIN,
    PF_SIN_SCALE,
    PF_WRITE
  } pf_state_t;

endpackage

### sv/pfv_if.sv
// ----------------------------------------------------------------------------
// pfv_if - request and vertex channels
// Valid/ready channels; a word moves on a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface pfv_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [pfv_pkg::COORD_W-1:0]  center_x;
  logic signed [pfv_pkg::COORD_W-1:0]  center_y;
  logic        [pfv_pkg::RADIUS_W-1:0] radius;
  logic        [pfv_pkg::COUNT_W-1:0]  num_vertices;
  logic        [pfv_pkg::ANGLE_W-1:0]  rotation;

  modport source (
    output valid, center_x, center_y, radius, num_vertices, rotation,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, radius, num_vertices, rotation,
    output ready
  );
endinterface

interface pfv_vtx_if;
  logic                               valid;
  logic                               ready;
  logic signed [pfv_pkg::COORD_W-1:0] vertex_x;
  logic signed [pfv_pkg::COORD_W-1:0] vertex_y;
  logic        [pfv_pkg::INDEX_W-1:0] vertex_index;
  logic                               last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, vertex_index, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, vertex_index, last_vertex,
    output ready
  );
endinterface

### sv/polygon_formation_vertices.sv
// ----------------------------------------------------------------------------
// polygon_formation_vertices - regular polygon vertex generator
// Turns a centre/radius/count/rotation request into one word per vertex.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with min(n, MAX_VERTICES)
// vertex words in index order, the last one flagged; n = 0 gives no words.
// A request first gets its angle step from a 32-step serial divide, then
// its vertices are made one by one. Most per-vertex work is in the sine
// unit, run once for cosine and once for sine: its polynomial needs six
// 32-step serial divisions and nine 4-bit-digit multiplies. Two scaling
// multiplies and the PF_LAUNCH and PF_WRITE control states make up the rest.
// A finished vertex sits in the output register, so the next vertex, or the
// next request after the last vertex, is worked on while it waits to be
// taken.
module polygon_formation_vertices #(
  parameter int MAX_VERTICES = pfv_pkg::MAX_VERTICES_DEF
) (
  input logic        clk,
  input logic        rst,
  pfv_req_if.sink    req,
  pfv_vtx_if.source  vtx
);

  localparam int CW = pfv_pkg::COORD_W;
  localparam int NW = pfv_pkg::COUNT_W;
  localparam int AW = pfv_pkg::ANGLE_W;
  localparam int W  = pfv_pkg::MUL_W;
  localparam int PW = pfv_pkg::PROD_W;
  localparam int SW = pfv_pkg::RADIUS_W + 1;
  localparam int EW = CW + 2;
  localparam logic signed [EW-1:0] SAT_HI = EW'((1 <<< (CW - 1)) - 1);
  localparam logic signed [EW-1:0] SAT_LO = -EW'(1 <<< (CW - 1));

  pfv_pkg::pf_state_t state, state_next;
  pfv_pkg::mul_req_t  mul_req;
  pfv_pkg::mul_rsp_t  mul_rsp;
  pfv_pkg::div_req_t  div_req;
  pfv_pkg::div_rsp_t  div_rsp;

  logic signed [CW-1:0]               cx;
  logic signed [CW-1:0]               cy;
  logic [pfv_pkg::RADIUS_W-1:0]       radius;
  logic [AW-1:0]                      rot;
  logic [NW-1:0]                      n;
  logic [AW:0]                        step;
  logic [NW-1:0]                      step_rem;
  logic [NW-1:0]                      i;
  logic [AW-1:0]                      qa;
  logic [NW-1:0]                      ra;
  logic                               trig_neg;
  logic signed [CW-1:0]               vx;
  logic signed [CW-1:0]               vy;

  logic                               ovalid;
  logic signed [CW-1:0]               ox;
  logic signed [CW-1:0]               oy;
  logic [pfv_pkg::INDEX_W-1:0]        oidx;
  logic                               olast;

  logic                               accept;
  logic                               load;
  logic                               last;
  logic [NW-1:0]                      n_clamp;
  logic [AW-1:0]                      ang;
  logic [AW-1:0]                      ang_cos;
  logic                               sin_start;
  logic [AW-1:0]                      sin_angle;
  logic                               sin_done;
  logic signed [pfv_pkg::TRIG_W-1:0]  sin_value;
  logic [pfv_pkg::TRIG_W-1:0]         mag;
  logic [SW-1:0]                      scaled;
  logic signed [EW-1:0]               base;
  logic signed [EW-1:0]               sum;
  logic signed [CW-1:0]               coord_sat;
  logic [NW:0]                        ra_sum;
  logic                               ra_wrap;

  pfv_mul  u_mul  (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  pfv_div  u_div  (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  pfv_sine u_sine (
    .clk   (clk),
    .rst   (rst),
    .start (sin_start),
    .angle (sin_angle),
    .done  (sin_done),
    .value (sin_value)
  );

  assign accept  = req.valid && req.ready;
  assign load    = (state == pfv_pkg::PF_WRITE) && (!ovalid || vtx.ready);
  assign last    = (i == n - 1'b1);
  assign n_clamp = (int'(req.num_vertices) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                           : req.num_vertices;

  // even counts: upper half pulled back by half a step
  assign ang = rot + qa
             - ((!n[0] && (i >= (n >> 1))) ? step[AW:1] : AW'(0));
  assign ang_cos = ang + AW'(16384);

  assign mag = sin_value[pfv_pkg::TRIG_W-1] ? pfv_pkg::TRIG_W'(16'd0 - sin_value)
                                            : sin_value;

  assign scaled = SW'((mul_rsp.prod + PW'(16384)) >> 15);
  assign base   = (state == pfv_pkg::PF_COS_SCALE) ? EW'(cx) : EW'(cy);
  assign sum    = trig_neg ? base - $signed(EW'(scaled)) : base + $signed(EW'(scaled));

  always_comb begin
    if (sum > SAT_HI) begin
      coord_sat = CW'(SAT_HI);
    end else if (sum < SAT_LO) begin
      coord_sat = CW'(SAT_LO);
    end else begin
      coord_sat = CW'(sum);
    end
  end

  assign ra_sum  = {1'b0, ra} + {1'b0, step_rem};
  assign ra_wrap = ra_sum >= {1'b0, n};

  always_comb begin
    state_next = state;
    case (state)
      pfv_pkg::PF_IDLE: begin
        if (accept && req.num_vertices != '0) state_next = pfv_pkg::PF_STEP;
      end
      pfv_pkg::PF_STEP:      if (div_rsp.done) state_next = pfv_pkg::PF_LAUNCH;
      pfv_pkg::PF_LAUNCH:    state_next = pfv_pkg::PF_COS;
      pfv_pkg::PF_COS:       if (sin_done) state_next = pfv_pkg::PF_COS_SCALE;
      pfv_pkg::PF_COS_SCALE: if (mul_rsp.done) state_next = pfv_pkg::PF_SIN;
      pfv_pkg::PF_SIN:       if (sin_done) state_next = pfv_pkg::PF_SIN_SCALE;
      pfv_pkg::PF_SIN_SCALE: if (mul_rsp.done) state_next = pfv_pkg::PF_WRITE;
      pfv_pkg::PF_WRITE: begin
        if (load) state_next = last ? pfv_pkg::PF_IDLE : pfv_pkg::PF_LAUNCH;
      end
      default:               state_next = pfv_pkg::PF_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == pfv_pkg::PF_IDLE);
    sin_start = 1'b0;
    sin_angle = ang;
    mul_req   = '0;
    div_req   = '0;
    case (state)
      pfv_pkg::PF_IDLE: begin
        div_req.start    = accept && req.num_vertices != '0;
        div_req.dividend = pfv_pkg::DIV_W'(1 << AW);
        div_req.divisor  = pfv_pkg::DIVISOR_W'(n_clamp);
      end
      pfv_pkg::PF_LAUNCH: begin
        sin_start = 1'b1;
        sin_angle = ang_cos;
      end
      pfv_pkg::PF_COS, pfv_pkg::PF_SIN: begin
        mul_req.start = sin_done;
        mul_req.a     = W'(radius);
        mul_req.b     = W'(mag);
      end
      pfv_pkg::PF_COS_SCALE: begin
        sin_start = mul_rsp.done;
      end
      default: begin
        sin_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pfv_pkg::PF_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (vtx.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx     <= req.center_x;
      cy     <= req.center_y;
      radius <= req.radius;
      rot    <= req.rotation;
      n      <= n_clamp;
    end
    if (state == pfv_pkg::PF_STEP && div_rsp.done) begin
      step     <= (AW+1)'(div_rsp.quot);
      step_rem <= NW'(div_rsp.rem);
      i        <= '0;
      qa       <= '0;
      ra       <= '0;
    end
    if ((state == pfv_pkg::PF_COS || state == pfv_pkg::PF_SIN) && sin_done) begin
      trig_neg <= sin_value[pfv_pkg::TRIG_W-1];
    end
    if (state == pfv_pkg::PF_COS_SCALE && mul_rsp.done) vx <= coord_sat;
    if (state == pfv_pkg::PF_SIN_SCALE && mul_rsp.done) vy <= coord_sat;
    if (load) begin
      ox    <= vx;
      oy    <= vy;
      oidx  <= pfv_pkg::INDEX_W'(i);
      olast <= last;
      if (!last) begin
        i  <= i + 1'b1;
        qa <= AW'(qa + step + (AW+1)'(ra_wrap));
        ra <= ra_wrap ? NW'(ra_sum - {1'b0, n}) : NW'(ra_sum);
      end
    end
  end

  assign vtx.valid        = ovalid;
  assign vtx.vertex_x     = ox;
  assign vtx.vertex_y     = oy;
  assign vtx.vertex_index = oidx;
  assign vtx.last_vertex  = olast;

endmodule

### sv/pfv_mul.sv
// ----------------------------------------------------------------------------
// pfv_mul - digit-serial unsigned multiplier
// Consumes one 4-bit digit of b per cycle, least significant first.
// ----------------------------------------------------------------------------
module pfv_mul (
  input  logic              clk,
  input  logic              rst,
  input  pfv_pkg::mul_req_t req,
  output pfv_pkg::mul_rsp_t rsp
);

  localparam int W     = pfv_pkg::MUL_W;
  localparam int D     = pfv_pkg::MUL_DIGIT_W;
  localparam int STEPS = W / D;
  localparam int CNT_W = $clog2(STEPS);

  logic [W-1:0]          a_op;
  logic [W-1:0]          b_sh;
  logic [2*W-1:0]        prod;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic [W+D-1:0]        sum;

  assign sum = {{D{1'b0}}, prod[2*W-1:W]} + ((W+D)'(a_op) * (W+D)'(b_sh[D-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_op <= req.a;
      b_sh <= req.b;
      prod <= '0;
    end else if (busy) begin
      prod <= {sum, prod[W-1:D]};
      b_sh <= b_sh >> D;
    end
  end

  assign rsp.done = done;
  assign rsp.prod = prod;

endmodule

### sv/pfv_div.sv
// ----------------------------------------------------------------------------
// pfv_div - bit-serial restoring divider
// One quotient bit per cycle, quotient and remainder valid with done.
// ----------------------------------------------------------------------------
module pfv_div (
  input  logic              clk,
  input  logic              rst,
  input  pfv_pkg::div_req_t req,
  output pfv_pkg::div_rsp_t rsp
);

  localparam int W     = pfv_pkg::DIV_W;
  localparam int V     = pfv_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     quo;
  logic [V-1:0]     rem;
  logic [V-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [V:0]       trial;
  logic [V:0]       diff;
  logic             ge;

  assign trial = {rem, quo[W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff[V-1:0] : trial[V-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;
  assign rsp.rem  = rem;

endmodule

### sv/pfv_sine.sv
// ----------------------------------------------------------------------------
// pfv_sine - Q1.15 sine sequencer
// Quarter-turn reduction, then a six-step Horner polynomial in Q30 run on a
// serial multiplier and a serial divider.
// ----------------------------------------------------------------------------
module pfv_sine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic        [pfv_pkg::ANGLE_W-1:0]  angle,
  output logic                                done,
  output logic signed [pfv_pkg::TRIG_W-1:0]   value
);

  localparam int          W      = pfv_pkg::MUL_W;
  localparam int          PW     = pfv_pkg::PROD_W;
  localparam logic [2:0]  K_LAST = 3'(pfv_pkg::HORNER_STEPS - 1);

  pfv_pkg::sine_state_t state, state_next;
  pfv_pkg::mul_req_t    mul_req;
  pfv_pkg::mul_rsp_t    mul_rsp;
  pfv_pkg::div_req_t    div_req;
  pfv_pkg::div_rsp_t    div_rsp;

  logic [1:0]    quad;
  logic [W-1:0]  x;
  logic [W-1:0]  x2;
  logic [2:0]    k;

  logic [14:0]   t_calc;
  logic [W-1:0]  x_calc;
  logic [W-1:0]  x2_calc;
  logic [W-1:0]  u_calc;
  logic [30:0]   p_calc;
  logic [16:0]   m_calc;
  logic signed [pfv_pkg::TRIG_W-1:0] val_calc;

  pfv_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  pfv_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // odd quadrants mirror the angle
  assign t_calc  = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign x_calc  = W'((mul_rsp.prod + PW'(16384)) >> 15);
  assign x2_calc = W'((mul_rsp.prod + PW'(536870912)) >> 30);
  assign u_calc  = W'(mul_rsp.prod >> 30);
  assign p_calc  = pfv_pkg::Q30_ONE - 31'(div_rsp.quot);
  assign m_calc  = 17'(((mul_rsp.prod >> 30) + PW'(16384)) >> 15);

  always_comb begin
    if (!quad[1]) begin
      val_calc = (m_calc > 17'd32767) ? 16'sd32767 : 16'(m_calc);
    end else begin
      val_calc = (m_calc > 17'd32768) ? -16'sd32768 : 16'(17'd0 - m_calc);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pfv_pkg::SIN_IDLE: if (start) state_next = pfv_pkg::SIN_X;
      pfv_pkg::SIN_X:    if (mul_rsp.done) state_next = pfv_pkg::SIN_SQ;
      pfv_pkg::SIN_SQ:   if (mul_rsp.done) state_next = pfv_pkg::SIN_HMUL;
      pfv_pkg::SIN_HMUL: if (mul_rsp.done) state_next = pfv_pkg::SIN_HDIV;
      pfv_pkg::SIN_HDIV: begin
        if (div_rsp.done) begin
          state_next = (k == K_LAST) ? pfv_pkg::SIN_FIN : pfv_pkg::SIN_HMUL;
        end
      end
      pfv_pkg::SIN_FIN:  if (mul_rsp.done) state_next = pfv_pkg::SIN_IDLE;
      default:           state_next = pfv_pkg::SIN_IDLE;
    endcase
  end

  always_comb begin
    mul_req = '0;
    div_req = '0;
    case (state)
      pfv_pkg::SIN_IDLE: begin
        mul_req.start = start;
        mul_req.a     = pfv_pkg::PI_Q30;
        mul_req.b     = W'(t_calc);
      end
      pfv_pkg::SIN_X: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = x_calc;
        mul_req.b     = x_calc;
      end
      pfv_pkg::SIN_SQ: begin
        mul_req.start = mul_rsp.done;
        mul_req.a     = x2_calc;
        mul_req.b     = W'(pfv_pkg::Q30_ONE);
      end
      pfv_pkg::SIN_HMUL: begin
        div_req.start    = mul_rsp.done;
        div_req.dividend = u_calc;
        div_req.divisor  = pfv_pkg::horner_div(k);
      end
      pfv_pkg::SIN_HDIV: begin
        mul_req.start = div_rsp.done;
        mul_req.a     = (k == K_LAST) ? x : x2;
        mul_req.b     = W'(p_calc);
      end
      default: begin
        mul_req = '0;
        div_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfv_pkg::SIN_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == pfv_pkg::SIN_FIN) && mul_rsp.done;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pfv_pkg::SIN_IDLE && start) quad <= angle[15:14];
    if (state == pfv_pkg::SIN_X && mul_rsp.done) x <= x_calc;
    if (state == pfv_pkg::SIN_SQ && mul_rsp.done) begin
      x2 <= x2_calc;
      k  <= '0;
    end
    if (state == pfv_pkg::SIN_HDIV && div_rsp.done) k <= k + 1'b1;
    if (state == pfv_pkg::SIN_FIN && mul_rsp.done) value <= val_calc;
  end

endmodule

### sv/pfv_checker.sv
// ----------------------------------------------------------------------------
// pfv_checker - port-level checks for the polygon vertex generator
// Watches the request and vertex channels; bound to the top level.
// ----------------------------------------------------------------------------
module pfv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic [pfv_pkg::COUNT_W-1:0]        req_num_vertices,
  input logic                               vtx_valid,
  input logic                               vtx_ready,
  input logic signed [pfv_pkg::COORD_W-1:0] vtx_vertex_x,
  input logic signed [pfv_pkg::COORD_W-1:0] vtx_vertex_y,
  input logic [pfv_pkg::INDEX_W-1:0]        vtx_vertex_index,
  input logic                               vtx_last_vertex
);

  logic [pfv_pkg::INDEX_W-1:0] nxt_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      nxt_idx <= '0;
    end else if (vtx_valid && vtx_ready) begin
      nxt_idx <= vtx_last_vertex ? '0 : nxt_idx + 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !vtx_valid)
    else $error("vertex word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    vtx_valid && !vtx_ready |=> vtx_valid && $stable(vtx_vertex_x)
      && $stable(vtx_vertex_y) && $stable(vtx_vertex_index)
      && $stable(vtx_last_vertex))
    else $error("stalled vertex word changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_num_vertices != '0 |=> !req_ready)
    else $error("request taken while a request is in progress");

  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    vtx_valid |-> vtx_vertex_index == nxt_idx)
    else $error("vertex index out of sequence");

endmodule

bind polygon_formation_vertices pfv_checker u_pfv_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_num_vertices (req.num_vertices),
  .vtx_valid        (vtx.valid),
  .vtx_ready        (vtx.ready),
  .vtx_vertex_x     (vtx.vertex_x),
  .vtx_vertex_y     (vtx.vertex_y),
  .vtx_vertex_index (vtx.vertex_index),
  .vtx_last_vertex  (vtx.last_vertex)
);

### verif/tb_polygon_formation_vertices.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polygon_formation_vertices - polygon vertex generator testbench
// Sends requests and checks every vertex word, most against an in-bench
// fixed-point predictor (angle spacing, Q1.15 sine series, rounded scaling,
// saturation). A directed table covers count and coordinate extremes, then
// randomized bursts run with random request gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_polygon_formation_vertices;

  localparam int COORD_W  = pfv_pkg::COORD_W;
  localparam int RADIUS_W = pfv_pkg::RADIUS_W;
  localparam int COUNT_W  = pfv_pkg::COUNT_W;
  localparam int ANGLE_W  = pfv_pkg::ANGLE_W;
  localparam int INDEX_W  = pfv_pkg::INDEX_W;
  localparam int MAX_V = pfv_pkg::MAX_VERTICES_DEF;
  localparam int N_RANDOM = 328;
  localparam int DRAIN_CYCLES = 2000;
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
  localparam longint unsigned ONE_Q30 = 64'(pfv_pkg::Q30_ONE);
  localparam longint unsigned PI_Q30  = 64'(pfv_pkg::PI_Q30);

  typedef struct {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RADIUS_W-1:0]       radius;
    logic [COUNT_W-1:0]        num_vertices;
    logic [ANGLE_W-1:0]        rotation;
  } request_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [INDEX_W-1:0]        index;
    logic                      last;
  } vertex_t;

  // how a directed row gets its expected words
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_CENTRE, CHK_SINGLE} row_check_t;

  typedef struct {
    row_check_t check;
    int cx;
    int cy;
    int radius;
    int n;
    int rot;
    int ex;
    int ey;
  } dir_row_t;

  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKE} sink_mode_t;

  localparam int DIR_ROWS = 22;
  dir_row_t directed [DIR_ROWS] = '{
    '{CHK_NONE,           0,        0,       0,  0,     0,        0,        0},
    '{CHK_NONE,     8388607, -8388608, 4194303,  0, 65535,        0,        0},
    '{CHK_CENTRE,         0,        0,       0,  1,     0,        0,        0},
    '{CHK_CENTRE,   8388607, -8388608,       0, 16, 12345,        0,        0},
    '{CHK_SINGLE,   8388607,       77, 4194303,  1,     0,  8388607,       77},
    '{CHK_SINGLE,  -8388608,        5, 4194303,  1, 32768, -8388608,        5},
    '{CHK_SINGLE,      -300,  8388607, 4194303,  1, 16384,     -300,  8388607},
    '{CHK_SINGLE,      1000, -8388608, 4194303,  1, 49152,     1000, -8388608},
    '{CHK_PREDICT,        0,        0,       1,  1,     0,        0,        0},
    '{CHK_PREDICT,        0,        0, 4194303,  2,     0,        0,        0},
    '{CHK_PREDICT,      -17,       42, 1000000,  3,   100,        0,        0},
    '{CHK_PREDICT, -8388608,  8388607, 4194303,  4, 65535,        0,        0},
    '{CHK_PREDICT,   123456,  -654321, 2097152,  5,  8191,        0,        0},
    '{CHK_PREDICT,        0,        0, 2097152,  6,     1,        0,        0},
    '{CHK_PREDICT,     4096,    -4096,   65535,  7, 40000,        0,        0},
    '{CHK_PREDICT,        0,        0,       1,  8,     0,        0,        0},
    '{CHK_PREDICT,       -1,       -1,       2, 12,  2731,        0,        0},
    '{CHK_PREDICT,  8388607,  8388607, 4194303, 15, 16383,        0,        0},
    '{CHK_PREDICT,        0,        0, 4194303, 16,     0,        0,        0},
    '{CHK_PREDICT, -4194304,  4194304, 3000000, 17, 32767,        0,        0},
    '{CHK_PREDICT,  8388607, -8388608, 4194303, 31, 65535,        0,        0},
    '{CHK_PREDICT,      999,     -999,   32768,  9, 49153,        0,        0}
  };

  logic clk;
  logic rst;

  pfv_req_if req ();
  pfv_vtx_if vtx ();

  polygon_formation_vertices #(
    .MAX_VERTICES(MAX_V)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .vtx(vtx)
  );

  vertex_t    pending_vertices[$];
  int         mismatches = 0;
  int         burst_left = 0;
  int         hold_left = 0;
  sink_mode_t sink_mode = SINK_OPEN;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Q1.15 sine of a 16-bit angle, odd series evaluated in Q30
  function automatic longint trig_lookup(input logic [ANGLE_W-1:0] ang);
    logic [1:0]      quad;
    longint unsigned r;
    longint unsigned t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned mag;
    longint          v;
    quad = ang[15:14];
    r = 64'(ang[13:0]);
    t = quad[0] ? (64'd16384 - r) : r;
    x = (t * PI_Q30 + 64'd16384) >> 15;
    x2 = (x * x + (ONE_Q30 >> 1)) >> 30;
    p = ONE_Q30;
    for (int k = 6; k >= 1; k--) begin
      p = ONE_Q30 - (x2 * p) / (64'((2 * k) * (2 * k + 1)) * ONE_Q30);
    end
    mag = (((x * p) >> 30) + 64'd16384) >> 15;
    v = quad[1] ? -longint'(mag) : longint'(mag);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic longint radial_offset(input logic [RADIUS_W-1:0] rad, input longint trig);
    longint unsigned mag;
    longint unsigned prod;
    mag = (trig < 0) ? -trig : trig;
    prod = (64'(rad) * mag + 64'd16384) >> 15;
    return (trig < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return COORD_W'(v);
  endfunction

  function automatic void push_vertex(input longint x, input longint y, input int idx,
                                      input logic last);
    vertex_t e;
    e.x = COORD_W'(x);
    e.y = COORD_W'(y);
    e.index = INDEX_W'(idx);
    e.last = last;
    pending_vertices = {pending_vertices, e};
  endfunction

  function automatic void polygon_vertices(input request_t w);
    int unsigned n;
    int unsigned ang;
    longint      cx;
    longint      cy;
    logic [ANGLE_W-1:0] a;
    n = w.num_vertices;
    if (n > MAX_V) n = MAX_V;
    cx = w.center_x;
    cy = w.center_y;
    for (int unsigned i = 0; i < n; i++) begin
      ang = w.rotation + (i * 32'd65536) / n;
      if (n % 2 == 0 && i >= n / 2) ang -= 32768 / n;
      a = ang[ANGLE_W-1:0];
      push_vertex(clamp_coord(cx + radial_offset(w.radius, trig_lookup(a + 16'd16384))),
                  clamp_coord(cy + radial_offset(w.radius, trig_lookup(a))),
                  i, i == n - 1);
    end
  endfunction

  function automatic logic signed [COORD_W-1:0] random_coord();
    case ($urandom_range(0, 4))
      0:       return COORD_W'(COORD_MAX);
      1:       return COORD_W'(COORD_MIN);
      2:       return COORD_W'($signed($urandom_range(0, 8191)) - 4096);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t    w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) w.num_vertices = '0;
    else if (pick < 85) w.num_vertices = COUNT_W'($urandom_range(1, 4));
    else if (pick < 96) w.num_vertices = COUNT_W'($urandom_range(5, MAX_V));
    else w.num_vertices = COUNT_W'($urandom_range(MAX_V + 1, 31));
    case ($urandom_range(0, 3))
      0:       w.radius = RADIUS_W'($urandom_range(0, 255));
      1:       w.radius = '1;
      2:       w.radius = RADIUS_W'($urandom_range(0, 65535));
      default: w.radius = RADIUS_W'($urandom);
    endcase
    w.center_x = random_coord();
    w.center_y = random_coord();
    if ($urandom_range(0, 4) == 0)
      w.rotation = ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
    else
      w.rotation = ANGLE_W'($urandom);
    return w;
  endfunction

  // returns at the edge that takes the word; valid is left high
  task automatic put_request(input request_t w);
    req.valid        <= 1'b1;
    req.center_x     <= w.center_x;
    req.center_y     <= w.center_y;
    req.radius       <= w.radius;
    req.num_vertices <= w.num_vertices;
    req.rotation     <= w.rotation;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req.valid <= 1'b0;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 1500) : $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 6);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 2));
      hold_left = $urandom_range(50, 3000);
    end
    hold_left--;
    case (sink_mode)
      SINK_OPEN: vtx.ready <= 1'b1;
      SINK_COIN: vtx.ready <= 1'($urandom_range(0, 1));
      default:   vtx.ready <= (hold_left % 64) == 0;
    endcase
  end

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && vtx.valid && vtx.ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex word, index %0d", vtx.vertex_index);
        mismatches++;
      end else begin
        e = pending_vertices.pop_front();
        if (vtx.vertex_x !== e.x) begin
          $error("vertex_x: expected %0d, got %0d", e.x, vtx.vertex_x);
          mismatches++;
        end
        if (vtx.vertex_y !== e.y) begin
          $error("vertex_y: expected %0d, got %0d", e.y, vtx.vertex_y);
          mismatches++;
        end
        if (vtx.vertex_index !== e.index) begin
          $error("vertex_index: expected %0d, got %0d", e.index, vtx.vertex_index);
          mismatches++;
        end
        if (vtx.last_vertex !== e.last) begin
          $error("last_vertex: expected %0d, got %0d", e.last, vtx.last_vertex);
          mismatches++;
        end
      end
    end
  end

  initial begin
    request_t w;
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.center_x     <= '0;
    req.center_y     <= '0;
    req.radius       <= '0;
    req.num_vertices <= '0;
    req.rotation     <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) begin
      w.center_x     = COORD_W'(directed[k].cx);
      w.center_y     = COORD_W'(directed[k].cy);
      w.radius       = RADIUS_W'(directed[k].radius);
      w.num_vertices = COUNT_W'(directed[k].n);
      w.rotation     = ANGLE_W'(directed[k].rot);
      put_request(w);
      case (directed[k].check)
        CHK_PREDICT: polygon_vertices(w);
        CHK_CENTRE: begin
          for (int v = 0; v < directed[k].n; v++)
            push_vertex(directed[k].cx, directed[k].cy, v, v == directed[k].n - 1);
        end
        CHK_SINGLE: push_vertex(directed[k].ex, directed[k].ey, 0, 1'b1);
        default: ;
      endcase
      pace();
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      w = random_request();
      put_request(w);
      polygon_vertices(w);
      pace();
    end
    req.valid <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // worst case: every request at full count, long gaps and stalls
  initial begin
    #250_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
sv/pfv_pkg.sv
sv/pfv_if.sv
sv/pfv_mul.sv
sv/pfv_div.sv
sv/pfv_sine.sv
sv/polygon_formation_vertices.sv
sv/pfv_checker.sv
verif/tb_polygon_formation_vertices.sv
